/* design/crcr_pkg.sv */
// Package: widths, reset values, register indexes and mask helper for the CRC remainder block.
`default_nettype none

package crcr_pkg;

   // field widths
   localparam int DEG_W  = 6;
   localparam int REM_W  = 63;
   localparam int BYTE_W = 8;
   localparam int CSR_IDX_W = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR = 1'd1;

   // configuration reset values
   localparam logic [DEG_W-1:0] DEGREE_RESET    = 6'd8;
   localparam logic [REM_W-1:0] GENERATOR_RESET = 63'h07;

   typedef logic [REM_W-1:0] rem_type;

   // ones in the low deg bits
   function automatic rem_type crcr_low_mask(input logic [DEG_W-1:0] deg);
      logic [REM_W:0] full;
      full = ({{REM_W{1'b0}}, 1'b1} << deg) - {{REM_W{1'b0}}, 1'b1};
      return full[REM_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/crcr_byte_step.sv */
// Combinational update of the remainder by one byte, eight bit steps, MSB first.
`default_nettype none

module crcr_byte_step
   import crcr_pkg::*;
(
   input  wire rem_type           rem_cur,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic [DEG_W-1:0]  degree,
   input  wire rem_type           generator,
   output rem_type                rem_next
);

   rem_type mask;
   rem_type top_sel;
   rem_type gen_masked;

   // derive the degree mask and the one-hot select of the top remainder bit
   always_comb begin
      mask       = crcr_low_mask(degree);
      top_sel    = mask & ~(mask >> 1);
      gen_masked = generator & mask;
   end

   // shift in each bit, reduce when the bit leaving the top is set
   always_comb begin
      rem_type r;
      logic    fb;
      r = rem_cur & mask;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         fb = |(r & top_sel);
         r  = ({r[REM_W-2:0], data_byte[3'(k)]} ^ (fb ? gen_masked : '0)) & mask;
      end
      rem_next = r;
   end

endmodule

`default_nettype wire

/* design/configurable_crc_remainder.sv */
// Top level: configurable MSB-first CRC remainder over byte frames.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one frame byte per
//   request with a last-byte flag. Bytes are shifted in MSB first; the
//   generator has an implied leading term of degree csr degree register.
//   Result channel (rsp_valid / rsp_stall) carries one remainder per frame,
//   masked to the configured degree; a degree of zero yields zero.
//   A frame's last byte passes the input register, then the result register.
//   Throughput is one byte per cycle unless a last byte waits on a stalled
//   result; the cycle is set by the eight chained bit steps, each picking
//   the top remainder bit by the configured degree.
//   Reset clears the remainder, empties both registers and loads degree 8
//   with generator low bits 0x07.
//   When the receiver stalls, the result register holds; non-last bytes
//   keep flowing, and a last byte waits in the input register, which then
//   stalls the request side.
//   Configuration is written through csr_write_enable / csr_index /
//   csr_write_data and takes effect on the next byte.
`default_nettype none

module configurable_crc_remainder
   import crcr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   input  wire logic                 req_last_byte,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [REM_W-1:0]          rsp_remainder,
   // configuration
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REM_W-1:0]     csr_write_data
);

   logic [DEG_W-1:0]  degree_ff;
   rem_type           generator_ff;
   rem_type           rem_ff;
   rem_type           rem_in;
   rem_type           rem_step;
   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_data_ff;
   logic              in_last_ff;
   logic              rsp_vld_ff;
   rem_type           rsp_rem_ff;
   logic              out_free;
   logic              proc_go;
   logic              emit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= DEGREE_RESET;
         generator_ff <= GENERATOR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEGREE:    degree_ff    <= csr_write_data[DEG_W-1:0];
            CSR_GENERATOR: generator_ff <= csr_write_data;
            default:       ;
         endcase
      end
   end

   // advance the held request when it produces nothing or the result slot frees up
   always_comb begin
      out_free  = !rsp_vld_ff || !rsp_stall;
      proc_go   = in_vld_ff && (!in_last_ff || out_free);
      emit      = proc_go && in_last_ff;
      req_stall = in_vld_ff && !proc_go;
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   crcr_byte_step u_step (
      .rem_cur   (rem_ff),
      .data_byte (in_data_ff),
      .degree    (degree_ff),
      .generator (generator_ff),
      .rem_next  (rem_step)
   );

   // update the remainder, clear it at the end of a frame
   always_comb begin
      rem_in = rem_ff;
      if (proc_go) begin
         rem_in = in_last_ff ? '0 : rem_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_rem_ff <= rem_step;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_remainder = rsp_rem_ff;

   // a finished frame always lands in the result register
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_vld_ff)
      else $error("result not raised after last byte");

   // the remainder restarts from zero after each frame
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rem_ff == '0))
      else $error("remainder not cleared at end of frame");

   // a byte that closes no frame never holds up the request side
   a_no_stall_mid: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !in_last_ff) |-> !req_stall)
      else $error("stall on a non-last byte");

   // a stalled result is not overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stall) |-> !emit)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the configurable MSB-first CRC remainder block.
`timescale 1ns / 1ps

module testbench;
   import crcr_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [REM_W-1:0]     rsp_remainder;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEGREE;
   logic [REM_W-1:0]     csr_write_data = '0;

   // predictor copy of the configuration and the running remainder
   logic [DEG_W-1:0] model_degree = DEGREE_RESET;
   logic [REM_W-1:0] model_poly = GENERATOR_RESET;
   logic [63:0]      model_remainder = '0;

   rem_type expected_remainders[$];
   int      error_count = 0;
   int      bytes_sent = 0;
   int      req_idle_pct = 0;
   int      rsp_stall_pct = 0;

   configurable_crc_remainder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_remainder    (rsp_remainder),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // shift one byte MSB first into the remainder, reducing by the generator
   function automatic logic [63:0] shift_in_byte(input logic [63:0] state,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic [DEG_W-1:0] degree,
                                                 input logic [REM_W-1:0] poly);
      logic [63:0] mask;
      logic [63:0] taps;
      logic [63:0] r;
      mask = (64'd1 << degree) - 64'd1;
      taps = {1'b0, poly} & mask;
      r = state & mask;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         r = {r[62:0], data[3'(k)]};
         if (r[degree])
            r = r ^ taps;
         r = r & mask;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input rem_type got,
                                  input rem_type want);
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // drive one request and hold it until the block takes it
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      model_remainder = shift_in_byte(model_remainder, data, model_degree, model_poly);
      if (last) begin
         expected_remainders.push_back(model_remainder[REM_W-1:0]);
         model_remainder = '0;
      end
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // hold off requests until every remainder is back and the pipeline is empty
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_remainders.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both registers; the degree word may carry junk above its field
   task automatic load_config(input logic [REM_W-1:0] degree_word,
                              input logic [REM_W-1:0] poly);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DEGREE;
      csr_write_data <= degree_word;
      @(posedge clock);
      model_degree = degree_word[DEG_W-1:0];
      csr_index <= CSR_GENERATOR;
      csr_write_data <= poly;
      @(posedge clock);
      model_poly = poly;
      csr_write_enable <= 1'b0;
   endtask

   function automatic rem_type random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[REM_W-1:0];
   endfunction

   task automatic load_random_config();
      logic [DEG_W-1:0] degree;
      rem_type          poly;
      rem_type          junk;
      case ($urandom_range(7))
         0: degree = '0;
         1: degree = '1;
         2: degree = 6'd1;
         default: degree = DEG_W'($urandom_range(63));
      endcase
      case ($urandom_range(5))
         0: poly = '1;
         1: poly = '0;
         default: poly = random_word();
      endcase
      junk = random_word();
      load_config({junk[REM_W-1:DEG_W], degree}, poly);
   endtask

   // compare each taken remainder with the oldest prediction; stall at random
   always @(posedge clock) begin : check_results
      rem_type want;
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_remainders.size() == 0) begin
            report_mismatch("unexpected remainder", rsp_remainder, '0);
         end else begin
            want = expected_remainders.pop_front();
            if (rsp_remainder !== want)
               report_mismatch("remainder", rsp_remainder, want);
         end
      end
   end

   // reset values: degree 8, generator 0x07
   task automatic test_reset_config();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'hA5, 1'b1);
   endtask

   // degree zero, one and the widest degree
   task automatic test_degree_extremes();
      load_config(REM_W'(0), '1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'hFF, 1'b1);
      load_config(REM_W'(1), REM_W'(1));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7E, 1'b1);
      load_config(REM_W'(63), '1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      load_config({{(REM_W-DEG_W){1'b1}}, 6'd63}, {1'b0, {(REM_W-1){1'b1}}});
      send_byte(8'h5A, 1'b1);
   endtask

   // generator bits at or above the degree must be ignored
   task automatic test_high_generator_bits();
      load_config(REM_W'(4), '1);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);
      load_config(REM_W'(4), REM_W'(3));
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);
   endtask

   // change the configuration in the middle of a frame
   task automatic test_mid_frame_config();
      load_config(REM_W'(16), REM_W'(16'h1021));
      send_byte(8'h31, 1'b0);
      send_byte(8'h32, 1'b0);
      load_config(REM_W'(8), REM_W'(8'h07));
      send_byte(8'h33, 1'b1);
   endtask

   task automatic send_random_frame();
      int          len;
      logic [7:0]  data;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 1; i <= len; i++) begin
         if (i > 1 && $urandom_range(29) == 0)
            load_random_config();
         case ($urandom_range(9))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom_range(255));
         endcase
         send_byte(data, i == len);
      end
   endtask

   // random frames under three idling patterns
   task automatic test_random_frames();
      int stop_at;
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               req_idle_pct = 17;
               rsp_stall_pct = 88;
            end
            1: begin
               req_idle_pct = 88;
               rsp_stall_pct = 17;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         stop_at = bytes_sent + 545;
         while (bytes_sent < stop_at) begin
            if ($urandom_range(3) == 0)
               load_random_config();
            send_random_frame();
         end
         wait_for_idle();
      end
   endtask

   initial begin
      req_idle_pct = 17;
      rsp_stall_pct = 88;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_degree_extremes();
      test_high_generator_bits();
      test_mid_frame_config();
      test_random_frames();
      wait_for_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
